// ===== sv/polar_go_to_goal_controller_defines.svh =====
// assertion macros for the go-to-goal controller
`ifndef POLAR_GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define POLAR_GO_TO_GOAL_CONTROLLER_DEFINES_SVH

// condition implies consequence in the same cycle
`define PG_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("pg assertion failed");

// condition implies consequence in the next cycle
`define PG_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("pg assertion failed");

`endif

// ===== sv/pgc_pkg.sv =====
package pgc_pkg;
  localparam int CORDIC_STAGES  = 16;
  localparam int POSITION_WIDTH = 32;
  localparam int GUARD_BITS     = 8;
  // cordic datapath width: position difference plus guard and growth
  localparam int CW = POSITION_WIDTH + GUARD_BITS + 4;
  localparam int AW = 21;  // q16 angle width
  localparam logic signed [AW-1:0] ANG_PI      = 21'sd205887;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 21'sd411775;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 21'sd102944;
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
  localparam logic [40:0] PROD_CAP = 41'h0FF_FFFF_FFFF;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_GAIN_DIST = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GAIN_HEAD = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HEAD_THR  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_REACH_THR = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ANG_LIM   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_LIN_LIM   = 3'd5;

  typedef struct packed {
    logic [15:0] gain_distance;
    logic [15:0] gain_heading;
    logic [14:0] heading_threshold;
    logic [30:0] reach_threshold;
    logic [15:0] angular_limit;
    logic [15:0] linear_limit;
  } cfg_t;

  function automatic logic signed [AW-1:0] atan_q16(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 21'sd51472;  1: r = 21'sd30386;  2: r = 21'sd16055;  3: r = 21'sd8150;
      4: r = 21'sd4091;   5: r = 21'sd2047;   6: r = 21'sd1024;   7: r = 21'sd512;
      8: r = 21'sd256;    9: r = 21'sd128;    10: r = 21'sd64;    11: r = 21'sd32;
      12: r = 21'sd16;    13: r = 21'sd8;     14: r = 21'sd4;     15: r = 21'sd2;
      16: r = 21'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== sv/pgc_if.sv =====
interface pgc_in_if import pgc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [POSITION_WIDTH-1:0] target_x;
  logic signed [POSITION_WIDTH-1:0] target_y;
  logic signed [POSITION_WIDTH-1:0] robot_x;
  logic signed [POSITION_WIDTH-1:0] robot_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, target_x, target_y, robot_x, robot_y,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, target_x, target_y, robot_x, robot_y,
                quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface pgc_out_if;
  logic valid;
  logic ready;
  logic [15:0] linear_speed;
  logic signed [16:0] angular_speed;
  modport source (output valid, linear_speed, angular_speed, input ready);
  modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

// ===== sv/pgc_vec_stage.sv =====
// one vectoring cordic micro-rotation, registered
module pgc_vec_stage import pgc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           stage,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [AW-1:0] z_in,
  output logic signed [CW-1:0] x_r,
  output logic signed [CW-1:0] y_r,
  output logic signed [AW-1:0] z_r
);
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] z_nxt;

  // rotate toward the x axis, stage index tied off by the parent
  always_comb begin
    if (y_in[CW-1]) begin
      x_nxt = x_in - (y_in >>> stage);
      y_nxt = y_in + (x_in >>> stage);
      z_nxt = z_in - atan_q16(int'(stage));
    end else begin
      x_nxt = x_in + (y_in >>> stage);
      y_nxt = y_in - (x_in >>> stage);
      z_nxt = z_in + atan_q16(int'(stage));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end
endmodule

// ===== sv/pgc_vec_cordic.sv =====
// pipelined vectoring cordic: angle in q16 and scaled magnitude
module pgc_vec_cordic import pgc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x,
  input  logic signed [CW-1:0] y,
  output logic signed [AW-1:0] angle,
  output logic signed [CW-1:0] mag
);
  logic signed [CW-1:0] xs [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys [CORDIC_STAGES+1];
  logic signed [AW-1:0] zs [CORDIC_STAGES+1];
  logic signed [CW-1:0] x0_r, y0_r;
  logic signed [AW-1:0] z0_r;
  logic                 zero_r;
  logic                 zero_d_r [CORDIC_STAGES];

  // pre-rotation into the right half plane, zero vector flagged
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= (x == '0) && (y == '0);
      if (x[CW-1] && !y[CW-1]) begin
        x0_r <= y <<< GUARD_BITS;
        y0_r <= -(x <<< GUARD_BITS);
        z0_r <= ANG_HALF_PI;
      end else if (x[CW-1]) begin
        x0_r <= -(y <<< GUARD_BITS);
        y0_r <= x <<< GUARD_BITS;
        z0_r <= -ANG_HALF_PI;
      end else begin
        x0_r <= x <<< GUARD_BITS;
        y0_r <= y <<< GUARD_BITS;
        z0_r <= '0;
      end
    end
  end

  assign xs[0] = x0_r;
  assign ys[0] = y0_r;
  assign zs[0] = z0_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    pgc_vec_stage u_st (
      .clk(clk), .en(en), .stage(5'(i)), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_r(xs[i+1]), .y_r(ys[i+1]), .z_r(zs[i+1]));
    always_ff @(posedge clk) begin
      if (en) zero_d_r[i] <= (i == 0) ? zero_r : zero_d_r[(i == 0) ? 0 : i-1];
    end
  end

  assign angle = zero_d_r[CORDIC_STAGES-1] ? '0 : zs[CORDIC_STAGES];
  assign mag   = (zero_d_r[CORDIC_STAGES-1] || xs[CORDIC_STAGES] <= 0) ? '0
                 : xs[CORDIC_STAGES];
endmodule

// ===== sv/pgc_cos_cordic.sv =====
// pipelined rotation cordic: cos of a q16 angle in q30
module pgc_cos_cordic import pgc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] angle,
  output logic signed [33:0]   cos_q30
);
  logic signed [33:0]   xs [CORDIC_STAGES+1];
  logic signed [33:0]   ys [CORDIC_STAGES+1];
  logic signed [AW-1:0] as_ [CORDIC_STAGES+1];
  logic                 neg_r [CORDIC_STAGES+1];

  // fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= 34'(INV_GAIN_Q30);
      ys[0] <= '0;
      if (angle > ANG_HALF_PI) begin
        as_[0] <= angle - ANG_PI; neg_r[0] <= 1'b1;
      end else if (angle < -ANG_HALF_PI) begin
        as_[0] <= angle + ANG_PI; neg_r[0] <= 1'b1;
      end else begin
        as_[0] <= angle; neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!as_[i][AW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          as_[i+1] <= as_[i] - atan_q16(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          as_[i+1] <= as_[i] + atan_q16(i);
        end
      end
    end
  end

  assign cos_q30 = neg_r[CORDIC_STAGES] ? -xs[CORDIC_STAGES] : xs[CORDIC_STAGES];
endmodule

// ===== sv/polar_go_to_goal_controller.sv =====
// channel | dir | payload
// in      | in  | target_x/y, robot_x/y (q16.16), quat_w/x/y/z (q2.14)
// out     | out | linear_speed (q8.8 unsigned), angular_speed (q8.8 signed)
// one pose per cycle while out is not stalled; the latency is set by the two
// cordic pipelines in series (heading, then cos of alpha).
// the whole pipeline advances together; a stall on out freezes every stage.
// rst_n is synchronous; it clears valid bits and restores register defaults.
`include "polar_go_to_goal_controller_defines.svh"
module polar_go_to_goal_controller import pgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [30:0]       cfg_data,
  pgc_in_if.sink            in_ch,
  pgc_out_if.source         out_ch
);
  localparam int VL = CORDIC_STAGES + 1;        // vectoring latency
  localparam int CL = CORDIC_STAGES + 1;        // cos latency
  localparam int NV = 1 + 1 + VL + 2 + CL + 3;  // stages ahead of the output register

  cfg_t cfg_r;
  logic en;
  logic vld_r [NV];
  logic out_vld_r;
  logic [15:0] lin_r;
  logic signed [16:0] ang_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'd256, 16'd256, 15'd6434, 31'd6554, 16'd256, 16'd128};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_DIST: cfg_r.gain_distance     <= cfg_data[15:0];
        REG_GAIN_HEAD: cfg_r.gain_heading      <= cfg_data[15:0];
        REG_HEAD_THR:  cfg_r.heading_threshold <= cfg_data[14:0];
        REG_REACH_THR: cfg_r.reach_threshold   <= cfg_data;
        REG_ANG_LIM:   cfg_r.angular_limit     <= cfg_data[15:0];
        REG_LIN_LIM:   cfg_r.linear_limit      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) vld_r[i] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NV; i++) vld_r[i] <= vld_r[i-1];
      out_vld_r <= vld_r[NV-1];
    end
  end

  // stage a: differences and quaternion products
  logic signed [CW-1:0] dx_r, dy_r;
  logic signed [31:0] qwz_r, qxy_r, qyy_r, qzz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= CW'(in_ch.target_x) - CW'(in_ch.robot_x);
      dy_r <= CW'(in_ch.target_y) - CW'(in_ch.robot_y);
      qwz_r <= in_ch.quat_w * in_ch.quat_z;
      qxy_r <= in_ch.quat_x * in_ch.quat_y;
      qyy_r <= in_ch.quat_y * in_ch.quat_y;
      qzz_r <= in_ch.quat_z * in_ch.quat_z;
    end
  end

  // stage b: yaw vector
  logic signed [CW-1:0] dx2_r, dy2_r, px_r, py_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r <= dx_r;
      dy2_r <= dy_r;
      py_r <= CW'(34'(qwz_r) + 34'(qxy_r)) <<< 1;
      px_r <= (CW'(1) <<< 28) - (CW'(34'(qyy_r) + 34'(qzz_r)) <<< 1);
    end
  end

  logic signed [AW-1:0] dest, yaw;
  logic signed [CW-1:0] mag, ymag;
  pgc_vec_cordic u_dest (.clk(clk), .en(en), .x(dx2_r), .y(dy2_r),
                         .angle(dest), .mag(mag));
  pgc_vec_cordic u_yaw (.clk(clk), .en(en), .x(px_r), .y(py_r),
                        .angle(yaw), .mag(ymag));

  // stage c1: raw alpha and rho partial products
  logic signed [AW:0] alpha_r;
  logic [63:0] rho_hi_r, rho_lo_r;
  logic [CW-1:0] mag_u;
  assign mag_u = mag;
  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r  <= (AW+1)'(dest) - (AW+1)'(yaw);
      rho_hi_r <= 64'(mag_u >> 24) * 64'(INV_GAIN_Q24);
      rho_lo_r <= (64'(mag_u[23:0]) * 64'(INV_GAIN_Q24)) >> 24;
    end
  end

  // stage c2: wrap alpha, finish rho
  logic signed [AW-1:0] a13_r;
  logic [47:0] rho_r;
  logic signed [AW:0] aw;
  logic [63:0] rho_full;
  always_comb begin
    aw = alpha_r;
    if (alpha_r > (AW+1)'(ANG_PI)) aw = alpha_r - (AW+1)'(ANG_TWO_PI);
    else if (alpha_r <= -(AW+1)'(ANG_PI)) aw = alpha_r + (AW+1)'(ANG_TWO_PI);
    rho_full = (rho_hi_r + rho_lo_r) >> GUARD_BITS;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a13_r <= AW'((aw + 22'sd4) >>> 3);
      rho_r <= rho_full[47:0];
    end
  end

  // stage c3: alpha and rho delayed alongside the cos cordic for the gain products and threshold tests
  logic signed [AW-1:0] a13_d_r [CL];
  logic [47:0] rho_d_r [CL];
  logic signed [38:0] wprod_r;
  logic [63:0] pprod_r;
  logic reached_r, head_ok_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a13_d_r[0] <= a13_r;
      rho_d_r[0] <= rho_r;
      for (int i = 1; i < CL; i++) begin
        a13_d_r[i] <= a13_d_r[i-1];
        rho_d_r[i] <= rho_d_r[i-1];
      end
    end
  end

  logic signed [33:0] cosv;
  pgc_cos_cordic u_cos (.clk(clk), .en(en), .angle(AW'(a13_r <<< 3)), .cos_q30(cosv));

  // after cos: gains against delayed alpha and rho
  logic signed [AW-1:0] a13_e;
  logic [47:0] rho_e;
  assign a13_e = a13_d_r[CL-1];
  assign rho_e = rho_d_r[CL-1];
  logic signed [33:0] cos_r;
  logic [40:0] p_r;
  always_ff @(posedge clk) begin
    if (en) begin
      wprod_r   <= 39'($signed({1'b0, cfg_r.gain_heading})) * 39'(a13_e) + 39'sd4096;
      pprod_r   <= 64'(cfg_r.gain_distance) * 64'(rho_e);
      reached_r <= rho_e < 48'(cfg_r.reach_threshold);
      head_ok_r <= (a13_e[AW-1] ? AW'(-a13_e) : a13_e) < AW'(cfg_r.heading_threshold);
      cos_r     <= cosv;
    end
  end

  // saturate, scale by cos
  logic signed [33:0] cos2_r;
  logic signed [25:0] w_r;
  logic reached2_r, head_ok2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (pprod_r > 64'(PROD_CAP)) ? PROD_CAP : pprod_r[40:0];
      w_r <= 26'(wprod_r >>> 13);
      cos2_r <= cos_r;
      reached2_r <= reached_r;
      head_ok2_r <= head_ok_r;
    end
  end

  logic [64:0] lin_prod_r;
  logic signed [25:0] w2_r;
  logic cos_pos_r, reached3_r, head_ok3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      lin_prod_r <= 65'(p_r >> 8) * 65'(cos2_r[32:0]);
      cos_pos_r  <= cos2_r > 0;
      w2_r <= w_r;
      reached3_r <= reached2_r;
      head_ok3_r <= head_ok2_r;
    end
  end

  // final clamps and output register
  logic [26:0] lin_v;
  logic signed [25:0] lim;
  assign lin_v = 27'(lin_prod_r >> 38);
  assign lim = 26'($signed({1'b0, cfg_r.angular_limit}));
  always_ff @(posedge clk) begin
    if (en) begin
      if (reached3_r) begin
        lin_r <= '0;
        ang_r <= '0;
      end else begin
        if (!head_ok3_r || !cos_pos_r) lin_r <= '0;
        else if (lin_v > 27'(cfg_r.linear_limit)) lin_r <= cfg_r.linear_limit;
        else lin_r <= lin_v[15:0];
        if (w2_r > lim) ang_r <= 17'(lim);
        else if (w2_r < -lim) ang_r <= 17'(-lim);
        else ang_r <= 17'(w2_r);
      end
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.linear_speed = lin_r;
  assign out_ch.angular_speed = ang_r;

  `PG_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_vld_r && !out_ch.ready, out_vld_r && $stable(lin_r))
  `PG_ASSERT_IMP(a_lin_lim, clk, rst_n, out_vld_r, lin_r <= cfg_r.linear_limit)
  `PG_ASSERT_IMP(a_ready, clk, rst_n, !out_vld_r, in_ch.ready)
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import pgc_pkg::*;

  typedef struct packed {
    logic [15:0]        lin;
    logic signed [16:0] ang;
  } speed_cmd_t;

  typedef struct packed {
    logic signed [31:0] tx, ty, rx, ry;
    logic signed [15:0] qw, qx, qy, qz;
    bit                 typed;
    logic [15:0]        lin;
    logic signed [16:0] ang;
  } pose_row_t;

  localparam int NUM_ROWS = 14;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 142;
  localparam longint unsigned PRODUCT_CAP = (64'd1 << 40) - 1;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd6;
  localparam logic [CFG_AW-1:0] REG_UNUSED_TOP = 3'd7;

  // directed poses: zero, extremes, degenerate and out-of-range quaternions
  localparam pose_row_t POSE_ROWS [NUM_ROWS] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 17'sd0},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
      16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 17'sd0},
    '{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
      1'b0, 16'd0, 17'sd0},
    '{32'h7FFFFFFF, 32'sd0, 32'h80000000, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
      1'b0, 16'd0, 17'sd0},
    '{-32'sd65536, 32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
      1'b0, 16'd0, 17'sd0},
    '{32'sd30000, 32'sd90000, 32'sd0, 32'sd0, -16'sd16384, -16'sd16384, -16'sd16384,
      -16'sd16384, 1'b0, 16'd0, 17'sd0},
    '{32'sd30000, -32'sd90000, 32'sd0, 32'sd0, 16'sd16384, 16'sd16384, 16'sd16384,
      16'sd16384, 1'b0, 16'd0, 17'sd0},
    '{32'sd200000, 32'sd100000, 32'sd0, 32'sd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
      1'b0, 16'd0, 17'sd0},
    '{32'sd0, 32'sd65536, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      1'b0, 16'd0, 17'sd0},
    '{32'sd0, -32'sd65536, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
      1'b0, 16'd0, 17'sd0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 17'sd0},
    '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
      16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, 16'd0, 17'sd0},
    '{32'sd6554, 32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
      1'b0, 16'd0, 17'sd0},
    '{32'sd6553, 32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
      1'b1, 16'd0, 17'sd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  pgc_in_if in_ch ();
  pgc_out_if out_ch ();

  polar_go_to_goal_controller dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // register copies for the predictor
  longint unsigned k_dist, k_head, band_head, reach_min, lim_ang, lim_lin;

  speed_cmd_t pending_cmds[$];
  int fails = 0;
  int cmds_seen = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint atan_step(input int i);
    longint tbl [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tbl[i] : 0;
  endfunction

  // vectoring rotations: angle in q16 and scaled magnitude
  function automatic longint heading_of(input longint x0, input longint y0,
                                        output longint unsigned mag);
    longint x, y, z, t;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -longint'(ANG_HALF_PI);
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      t = x;
      if (y < 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - atan_step(i);
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + atan_step(i);
      end
    end
    mag = (x > 0) ? longint'(x) : 0;
    return z;
  endfunction

  // rotation to get cos in q30
  function automatic longint cos_of(input longint a0);
    longint a, x, y, t;
    bit flip;
    a = a0;
    x = INV_GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (a > ANG_HALF_PI) begin
      a = a - ANG_PI; flip = 1'b1;
    end else if (a < -longint'(ANG_HALF_PI)) begin
      a = a + ANG_PI; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      t = x;
      if (a >= 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        a = a - atan_step(i);
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        a = a + atan_step(i);
      end
    end
    return flip ? -x : x;
  endfunction

  function automatic speed_cmd_t control_law(input pose_row_t p);
    speed_cmd_t r;
    longint dx, dy, qw, qx, qy, qz, py, px, bearing, yaw, alpha, a13, w, lim, c;
    longint unsigned mag, ymag, rho, prod, lin;
    dx = longint'(p.tx) - longint'(p.rx);
    dy = longint'(p.ty) - longint'(p.ry);
    qw = longint'(p.qw);
    qx = longint'(p.qx);
    qy = longint'(p.qy);
    qz = longint'(p.qz);
    bearing = heading_of(dx, dy, mag);
    rho = ((mag >> 24) * INV_GAIN_Q24
           + (((mag & 64'hFFFFFF) * INV_GAIN_Q24) >> 24)) >> 8;
    py = 2 * (qw * qz + qx * qy);
    px = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
    yaw = heading_of(px, py, ymag);
    alpha = bearing - yaw;
    if (alpha > ANG_PI) alpha = alpha - ANG_TWO_PI;
    else if (alpha <= -longint'(ANG_PI)) alpha = alpha + ANG_TWO_PI;
    a13 = (alpha + 4) >>> 3;
    r = '0;
    if (rho < reach_min) return r;
    lim = longint'(lim_ang);
    w = (longint'(k_head) * a13 + 4096) >>> 13;
    if (w > lim) w = lim;
    if (w < -lim) w = -lim;
    lin = 0;
    if (((a13 < 0) ? -a13 : a13) < longint'(band_head)) begin
      c = cos_of(a13 * 8);
      if (c > 0) begin
        if (k_dist == 0) prod = 0;
        else if (rho > PRODUCT_CAP / k_dist) prod = PRODUCT_CAP;
        else prod = k_dist * rho;
        lin = ((prod >> 8) * longint'(c)) >> 38;
        if (lin > lim_lin) lin = lim_lin;
      end
    end
    r.lin = lin[15:0];
    r.ang = w[16:0];
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    @(posedge clk);
    case (idx)
      REG_GAIN_DIST: k_dist = val & 16'hFFFF;
      REG_GAIN_HEAD: k_head = val & 16'hFFFF;
      REG_HEAD_THR:  band_head = val & 15'h7FFF;
      REG_REACH_THR: reach_min = val & 31'h7FFFFFFF;
      REG_ANG_LIM:   lim_ang = val & 16'hFFFF;
      REG_LIN_LIM:   lim_lin = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (CORDIC_STAGES * 2 + 20) @(posedge clk);
  endtask

  task automatic send_pose(input pose_row_t p);
    int gap;
    gap = idle_on ? $urandom_range(6, 0) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_x <= p.tx;
    in_ch.target_y <= p.ty;
    in_ch.robot_x <= p.rx;
    in_ch.robot_y <= p.ry;
    in_ch.quat_w <= p.qw;
    in_ch.quat_x <= p.qx;
    in_ch.quat_y <= p.qy;
    in_ch.quat_z <= p.qz;
    do @(posedge clk); while (!in_ch.ready);
    pending_cmds.push_back(p.typed ? speed_cmd_t'{p.lin, p.ang} : control_law(p));
  endtask

  function automatic logic signed [31:0] rand_pos(input logic signed [31:0] near);
    int sel;
    sel = $urandom_range(9, 0);
    if (sel < 2) return $urandom;
    if (sel < 5) return near + $signed($urandom_range(20000, 0)) - 10000;
    return near + $signed($urandom_range(2000000, 0)) - 1000000;
  endfunction

  function automatic logic signed [15:0] rand_quat();
    if ($urandom_range(3, 0) == 0) return $urandom;
    return $signed($urandom_range(32768, 0)) - 16384;
  endfunction

  // receiver: random stalls, one long hold on request
  initial begin
    int stall;
    speed_cmd_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(6, 0) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        $error("unexpected transaction: lin %0d ang %0d",
               out_ch.linear_speed, out_ch.angular_speed);
        fails++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.linear_speed !== want.lin) begin
          $error("linear_speed expected %0d actual %0d", want.lin, out_ch.linear_speed);
          fails++;
        end
        if (out_ch.angular_speed !== want.ang) begin
          $error("angular_speed expected %0d actual %0d", want.ang, out_ch.angular_speed);
          fails++;
        end
      end
    end
  end

  // stimulus
  initial begin
    pose_row_t p;
    int sent;
    in_ch.valid = 1'b0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.robot_x = '0;
    in_ch.robot_y = '0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    k_dist = 256; k_head = 256; band_head = 6434;
    reach_min = 6554; lim_ang = 256; lim_lin = 128;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under reset values
    for (int r = 0; r < NUM_ROWS; r++) send_pose(POSE_ROWS[r]);
    sent = NUM_ROWS;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      drain();
      // register settings: extremes first, then the reset values, then random
      case (ph)
        0: begin
          write_reg(REG_GAIN_DIST, 65535); write_reg(REG_GAIN_HEAD, 65535);
          write_reg(REG_HEAD_THR, 25736); write_reg(REG_REACH_THR, 0);
          write_reg(REG_ANG_LIM, 65535); write_reg(REG_LIN_LIM, 65535);
        end
        1: begin
          write_reg(REG_GAIN_DIST, 0); write_reg(REG_GAIN_HEAD, 0);
          write_reg(REG_HEAD_THR, 0); write_reg(REG_REACH_THR, 0);
          write_reg(REG_ANG_LIM, 0); write_reg(REG_LIN_LIM, 0);
        end
        2: begin
          write_reg(REG_REACH_THR, 31'h7FFFFFFF); write_reg(REG_HEAD_THR, 15'h7FFF);
          write_reg(REG_UNUSED, $urandom);
        end
        3: begin
          write_reg(REG_GAIN_DIST, 256); write_reg(REG_GAIN_HEAD, 256);
          write_reg(REG_HEAD_THR, 6434); write_reg(REG_REACH_THR, 6554);
          write_reg(REG_ANG_LIM, 256); write_reg(REG_LIN_LIM, 128);
          write_reg(REG_UNUSED_TOP, $urandom);
        end
        default: begin
          write_reg(REG_GAIN_DIST, $urandom_range(65535, 0));
          write_reg(REG_GAIN_HEAD, $urandom_range(65535, 0));
          write_reg(REG_HEAD_THR, $urandom_range(32767, 0));
          write_reg(REG_REACH_THR, $urandom_range(400000, 0));
          write_reg(REG_ANG_LIM, $urandom_range(65535, 0));
          write_reg(REG_LIN_LIM, $urandom_range(65535, 0));
        end
      endcase
      cfg_we <= 1'b0;
      idle_on = (ph != 4);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits for the block to empty once, in the middle of phase 5
        if (ph == 5 && n == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          while (pending_cmds.size() != 0) @(posedge clk);
        end
        p.rx = $urandom;
        if ($urandom_range(3, 0) != 0) p.rx = $signed(p.rx) >>> 8;
        p.ry = $urandom;
        if ($urandom_range(3, 0) != 0) p.ry = $signed(p.ry) >>> 8;
        p.tx = rand_pos(p.rx);
        p.ty = rand_pos(p.ry);
        p.qw = rand_quat();
        p.qx = rand_quat();
        p.qy = rand_quat();
        p.qz = rand_quat();
        p.typed = 1'b0;
        p.lin = '0;
        p.ang = '0;
        send_pose(p);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (CORDIC_STAGES * 2 + 20) @(posedge clk);
    $display("ran %0d poses over %0d register settings, %0d speed commands checked",
             sent, NUM_PHASES + 1, cmds_seen);
    $display("with random stalls, an output hold-off and a sender pause");
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
